// File: rtl/bfv_pkg.sv
`default_nettype none

package bfv_pkg;

  localparam int HEADER_BYTES_DEF = 20;
  localparam int STORE_BYTES      = 20;
  localparam int STORE_IDX_W      = $clog2(STORE_BYTES);
  localparam int CRC_FIRST_GAP    = 16;

  // wide enough that the saturated count lies above the largest total length
  localparam int COUNT_W = 27;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [31:0] CRC_POLY = 32'hedb8_8320;
  localparam logic [31:0] CRC_ONES = 32'hffff_ffff;

  localparam logic [7:0] MAGIC_0 = 8'h4d;
  localparam logic [7:0] MAGIC_1 = 8'h35;
  localparam logic [7:0] MAGIC_2 = 8'h46;
  localparam logic [7:0] MAGIC_3 = 8'h42;

  localparam logic [15:0] FORMAT_VERSION_RST = 16'd1;
  localparam logic [23:0] MAX_TEL_RST        = 24'd16384;
  localparam logic [23:0] MAX_FB_RST         = 24'd16384;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_HDR_SHORT  = 4'd1,
    ST_MAGIC      = 4'd2,
    ST_VERSION    = 4'd3,
    ST_HDR_LEN    = 4'd4,
    ST_TEL_RANGE  = 4'd5,
    ST_FB_RANGE   = 4'd6,
    ST_BODY_SHORT = 4'd7,
    ST_TRAILING   = 4'd8,
    ST_CRC        = 4'd9
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FORMAT_VERSION = 2'd0,
    CFG_MAX_TEL        = 2'd1,
    CFG_MAX_FB         = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    status_t     status;
    logic [23:0] telemetry_length;
    logic [23:0] feedback_length;
    logic [24:0] feedback_offset;
    logic [25:0] total_length;
    logic [31:0] frame_crc;
  } result_t;

  // reflected crc-32, one byte, bit by bit
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/bfv_in_if.sv
`default_nettype none

interface bfv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/bfv_out_if.sv
`default_nettype none

interface bfv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [23:0] telemetry_length;
  logic [23:0] feedback_length;
  logic [24:0] feedback_offset;
  logic [25:0] total_length;
  logic [31:0] frame_crc;

  modport source (
    output valid, output status, output telemetry_length, output feedback_length,
    output feedback_offset, output total_length, output frame_crc, input ready
  );
  modport sink (
    input valid, input status, input telemetry_length, input feedback_length,
    input feedback_offset, input total_length, input frame_crc, output ready
  );
endinterface

`default_nettype wire

// File: rtl/bfv_cfg_if.sv
`default_nettype none

interface bfv_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bfv_pkg::CFG_IDX_W-1:0]  index;
  logic [bfv_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/bundle_frame_validator_top.sv
// result path: a last byte that is taken passes through the byte register and then
//   the result register before its result is shown
// throughput: one byte per cycle; a waiting result only holds back a following
//   last byte, which sits in the byte register until the result is taken
// reset: synchronous, active low; clears the byte count, the crc, the valid flags
//   and returns the registers to their defaults; the header bytes are not cleared
`default_nettype none

module bundle_frame_validator_top #(
  parameter int HEADER_BYTES = bfv_pkg::HEADER_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bfv_in_if.sink       in_ch,
  bfv_out_if.source    out_ch,
  bfv_cfg_if.sink      cfg_ch
);

  localparam int                         CW       = bfv_pkg::COUNT_W;
  localparam logic [CW-1:0]              HDR_CNT  = CW'(HEADER_BYTES);
  localparam logic [15:0]                HDR_LEN  = 16'(HEADER_BYTES);
  localparam logic [CW-1:0]              GAP_CNT  = CW'(bfv_pkg::CRC_FIRST_GAP);
  localparam logic [CW-1:0]              STORE_CNT = CW'(bfv_pkg::STORE_BYTES);

  logic [15:0] fmt_ver_r;
  logic [23:0] max_tel_r;
  logic [23:0] max_fb_r;

  logic        s1_valid_r;
  logic        s1_last_r;
  logic [7:0]  s1_byte_r;

  logic [CW-1:0] count_r;
  logic [31:0]   crc_r;
  logic [7:0]    hdr_r [bfv_pkg::STORE_BYTES];

  bfv_pkg::result_t out_r;
  logic             out_valid_r;

  logic             out_free;
  logic             s1_adv;
  logic             in_acc;
  logic [CW-1:0]    count_nxt;
  logic [31:0]      crc_nxt;
  logic [7:0]       hdr_view [bfv_pkg::STORE_BYTES];
  logic [15:0]      ver;
  logic [15:0]      hlen;
  logic [31:0]      tel;
  logic [31:0]      fb;
  logic [31:0]      stored_crc;
  logic [CW-1:0]    total;
  logic [24:0]      offset;
  bfv_pkg::result_t res_nxt;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_ver_r <= bfv_pkg::FORMAT_VERSION_RST;
      max_tel_r <= bfv_pkg::MAX_TEL_RST;
      max_fb_r  <= bfv_pkg::MAX_FB_RST;
    end else if (cfg_ch.valid) begin
      unique case (bfv_pkg::cfg_idx_t'(cfg_ch.index))
        bfv_pkg::CFG_FORMAT_VERSION: fmt_ver_r <= cfg_ch.data[15:0];
        bfv_pkg::CFG_MAX_TEL:        max_tel_r <= cfg_ch.data;
        bfv_pkg::CFG_MAX_FB:         max_fb_r  <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_adv       = s1_valid_r && (!s1_last_r || out_free);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  // per byte update
  assign count_nxt = (count_r == '1) ? count_r : count_r + CW'(1);
  assign crc_nxt   = ((count_r < GAP_CNT) || (count_r >= HDR_CNT)) ?
                     bfv_pkg::crc_byte(crc_r, s1_byte_r) : crc_r;

  // header as it stands once the current byte is stored
  always_comb begin
    for (int i = 0; i < bfv_pkg::STORE_BYTES; i++) begin
      hdr_view[i] = (count_r == CW'(i)) ? s1_byte_r : hdr_r[i];
    end
  end

  assign ver        = {hdr_view[5], hdr_view[4]};
  assign hlen       = {hdr_view[7], hdr_view[6]};
  assign tel        = {hdr_view[11], hdr_view[10], hdr_view[9], hdr_view[8]};
  assign fb         = {hdr_view[15], hdr_view[14], hdr_view[13], hdr_view[12]};
  assign stored_crc = {hdr_view[19], hdr_view[18], hdr_view[17], hdr_view[16]};
  assign offset     = 25'(HEADER_BYTES) + 25'(tel[23:0]);
  assign total      = HDR_CNT + CW'(tel[23:0]) + CW'(fb[23:0]);

  always_comb begin
    res_nxt = '0;
    if (count_nxt < HDR_CNT) begin
      res_nxt.status = bfv_pkg::ST_HDR_SHORT;
    end else if (hdr_view[0] != bfv_pkg::MAGIC_0 || hdr_view[1] != bfv_pkg::MAGIC_1 ||
                 hdr_view[2] != bfv_pkg::MAGIC_2 || hdr_view[3] != bfv_pkg::MAGIC_3) begin
      res_nxt.status = bfv_pkg::ST_MAGIC;
    end else if (ver != fmt_ver_r) begin
      res_nxt.status = bfv_pkg::ST_VERSION;
    end else if (hlen != HDR_LEN) begin
      res_nxt.status = bfv_pkg::ST_HDR_LEN;
    end else if (tel == 32'd0 || tel > {8'd0, max_tel_r}) begin
      res_nxt.status = bfv_pkg::ST_TEL_RANGE;
    end else if (fb == 32'd0 || fb > {8'd0, max_fb_r}) begin
      res_nxt.status = bfv_pkg::ST_FB_RANGE;
    end else if (count_nxt < total) begin
      res_nxt.status = bfv_pkg::ST_BODY_SHORT;
    end else if (count_nxt > total) begin
      res_nxt.status = bfv_pkg::ST_TRAILING;
    end else if ((crc_nxt ^ bfv_pkg::CRC_ONES) != stored_crc) begin
      res_nxt.status = bfv_pkg::ST_CRC;
    end else begin
      res_nxt.status           = bfv_pkg::ST_OK;
      res_nxt.telemetry_length = tel[23:0];
      res_nxt.feedback_length  = fb[23:0];
      res_nxt.feedback_offset  = offset;
      res_nxt.total_length     = total[25:0];
      res_nxt.frame_crc        = stored_crc;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      count_r     <= '0;
      crc_r       <= bfv_pkg::CRC_ONES;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        if (s1_last_r) begin
          count_r <= '0;
          crc_r   <= bfv_pkg::CRC_ONES;
        end else begin
          count_r <= count_nxt;
          crc_r   <= crc_nxt;
        end
      end
      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
    if (s1_adv && s1_last_r) begin
      out_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (count_r < STORE_CNT)) begin
      hdr_r[count_r[bfv_pkg::STORE_IDX_W-1:0]] <= s1_byte_r;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_r.status;
  assign out_ch.telemetry_length = out_r.telemetry_length;
  assign out_ch.feedback_length  = out_r.feedback_length;
  assign out_ch.feedback_offset  = out_r.feedback_offset;
  assign out_ch.total_length     = out_r.total_length;
  assign out_ch.frame_crc        = out_r.frame_crc;

endmodule

`default_nettype wire

// File: rtl/bfv_checker.sv
`default_nettype none

module bfv_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_last,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  status,
  input wire logic [23:0] tel_len,
  input wire logic [23:0] fb_len,
  input wire logic [24:0] fb_off,
  input wire logic [25:0] total_len,
  input wire logic [31:0] frame_crc
);

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(total_len) &&
    $stable(frame_crc))
    else $error("result changed while stalled");

  // any error clears the reported lengths and crc
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != bfv_pkg::ST_OK) |->
    tel_len == 24'd0 && fb_len == 24'd0 && fb_off == 25'd0 &&
    total_len == 26'd0 && frame_crc == 32'd0)
    else $error("error result carries non-zero fields");

  // a good frame has consistent lengths
  a_ok_lengths: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == bfv_pkg::ST_OK) |->
    tel_len != 24'd0 && fb_len != 24'd0 &&
    total_len == 26'(fb_off) + 26'(fb_len) && fb_off > 25'(tel_len))
    else $error("inconsistent lengths in good result");

  // a fresh result follows a taken last byte that passed through the byte register
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last, 2))
    else $error("result without a last byte");

endmodule

bind bundle_frame_validator_top bfv_checker u_bfv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .status    (out_ch.status),
  .tel_len   (out_ch.telemetry_length),
  .fb_len    (out_ch.feedback_length),
  .fb_off    (out_ch.feedback_offset),
  .total_len (out_ch.total_length),
  .frame_crc (out_ch.frame_crc)
);

`default_nettype wire

// File: tb/bfv_frame_checker.sv
module bfv_frame_checker (
  input  logic clk,
  input  logic rst_n,
  bfv_in_if    in_ch,
  bfv_out_if   out_ch,
  bfv_cfg_if   cfg_ch,
  output int   fail_count,
  output int   pending
);
  import bfv_pkg::*;

  localparam int HDR_N    = HEADER_BYTES_DEF;
  localparam int CRC_SPAN = 16;

  logic [15:0] want_version;
  logic [23:0] tel_limit;
  logic [23:0] fb_limit;
  logic [31:0] frame_bytes;
  logic [31:0] crc_acc;
  logic [7:0]  hdr [HDR_N];
  result_t     frame_results [$];
  int          shown;

  // fold one byte into the frame state; on the last byte, queue the verdict
  function automatic void absorb_byte(input logic [7:0] b, input logic fin);
    result_t     r;
    logic [31:0] tel;
    logic [31:0] fb;
    logic [31:0] stored;
    logic [33:0] tot;
    if (frame_bytes < HDR_N) hdr[frame_bytes] = b;
    if (frame_bytes < CRC_SPAN || frame_bytes >= HDR_N) begin
      crc_acc = crc_acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        crc_acc = crc_acc[0] ? ((crc_acc >> 1) ^ CRC_POLY) : (crc_acc >> 1);
      end
    end
    if (frame_bytes != '1) frame_bytes++;
    if (!fin) return;

    r = '0;
    if (frame_bytes < HDR_N) begin
      r.status = ST_HDR_SHORT;
    end else if (hdr[0] != MAGIC_0 || hdr[1] != MAGIC_1 || hdr[2] != MAGIC_2 ||
                 hdr[3] != MAGIC_3) begin
      r.status = ST_MAGIC;
    end else if ({hdr[5], hdr[4]} != want_version) begin
      r.status = ST_VERSION;
    end else if ({hdr[7], hdr[6]} != 16'(HDR_N)) begin
      r.status = ST_HDR_LEN;
    end else begin
      tel    = {hdr[11], hdr[10], hdr[9], hdr[8]};
      fb     = {hdr[15], hdr[14], hdr[13], hdr[12]};
      stored = {hdr[19], hdr[18], hdr[17], hdr[16]};
      tot    = 34'(HDR_N) + 34'(tel) + 34'(fb);
      if (tel == 0 || tel > tel_limit) r.status = ST_TEL_RANGE;
      else if (fb == 0 || fb > fb_limit) r.status = ST_FB_RANGE;
      else if (34'(frame_bytes) < tot) r.status = ST_BODY_SHORT;
      else if (34'(frame_bytes) > tot) r.status = ST_TRAILING;
      else if (~crc_acc != stored) r.status = ST_CRC;
      else begin
        r.status           = ST_OK;
        r.telemetry_length = tel[23:0];
        r.feedback_length  = fb[23:0];
        r.feedback_offset  = 25'(HDR_N) + {1'b0, tel[23:0]};
        r.total_length     = tot[25:0];
        r.frame_crc        = stored;
      end
    end
    frame_results.push_back(r);
    frame_bytes = '0;
    crc_acc     = '1;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      want_version = FORMAT_VERSION_RST;
      tel_limit    = MAX_TEL_RST;
      fb_limit     = MAX_FB_RST;
      frame_bytes  = '0;
      crc_acc      = '1;
      frame_results.delete();
      fail_count   = 0;
      shown        = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (frame_results.size() == 0) begin
          fail_count++;
          if (shown < 10) begin
            shown++;
            $display("%0t: result with none outstanding, status %0d", $time, out_ch.status);
          end
        end else begin
          want = frame_results.pop_front();
          if (out_ch.status !== want.status ||
              out_ch.telemetry_length !== want.telemetry_length ||
              out_ch.feedback_length !== want.feedback_length ||
              out_ch.feedback_offset !== want.feedback_offset ||
              out_ch.total_length !== want.total_length ||
              out_ch.frame_crc !== want.frame_crc) begin
            fail_count++;
            if (shown < 10) begin
              shown++;
              $display("%0t: mismatch, expected st %0d tel %0d fb %0d off %0d tot %0d crc %h",
                       $time, want.status, want.telemetry_length, want.feedback_length,
                       want.feedback_offset, want.total_length, want.frame_crc);
              $display("%0t:            actual st %0d tel %0d fb %0d off %0d tot %0d crc %h",
                       $time, out_ch.status, out_ch.telemetry_length, out_ch.feedback_length,
                       out_ch.feedback_offset, out_ch.total_length, out_ch.frame_crc);
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_FORMAT_VERSION: want_version = cfg_ch.data[15:0];
          CFG_MAX_TEL:        tel_limit = cfg_ch.data;
          CFG_MAX_FB:         fb_limit = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) absorb_byte(in_ch.data_byte, in_ch.last_byte);
    end
    pending = frame_results.size();
  end

endmodule

// File: tb/tb.sv
module tb;
  import bfv_pkg::*;

  localparam int HDR_N       = HEADER_BYTES_DEF;
  localparam int PHASE_BYTES = 280;
  localparam int PHASES      = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 4000;

  typedef enum int {
    FR_OK, FR_HDR_SHORT, FR_MAGIC, FR_VERSION, FR_HDR_LEN, FR_TEL_RANGE,
    FR_FB_RANGE, FR_BODY_SHORT, FR_TRAILING, FR_CRC, FR_NOISE
  } frame_kind_t;

  logic        clk;
  logic        rst_n;
  int          fail_count;
  int          pending;
  int          sent;
  int          calm_frames;
  logic        hold_req;
  logic [15:0] cur_version;
  logic [23:0] tel_max;
  logic [23:0] fb_max;

  bfv_in_if  in_bus ();
  bfv_out_if out_bus ();
  bfv_cfg_if cfg_bus ();

  bundle_frame_validator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  bfv_frame_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_bus),
    .out_ch     (out_bus),
    .cfg_ch     (cfg_bus),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // mostly back to back, sometimes a short gap, rarely a long gap
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_len(input logic [23:0] mx);
    logic [23:0] top_len;
    top_len = ($urandom_range(0, 9) == 0) ? 24'd60 : 24'd8;
    if (mx < top_len) top_len = mx;
    return $urandom_range(1, top_len);
  endfunction

  function automatic logic [31:0] out_of_range(input logic [23:0] mx);
    case ($urandom_range(0, 2))
      0: return 32'd0;
      1: return {8'd0, mx} + $urandom_range(1, 4);
      default: return $urandom | 32'h8000_0000;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fin, input int gap);
    repeat (gap) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= fin;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // valid is left high; the caller lowers it after the last write
  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      CFG_FORMAT_VERSION: cur_version = val[15:0];
      CFG_MAX_TEL:        tel_max = val;
      CFG_MAX_FB:         fb_max = val;
      default: ;
    endcase
  endtask

  task automatic send_frame(input frame_kind_t kind);
    logic [7:0]   fr [$];
    logic [159:0] hdr_word;
    logic [31:0]  tel;
    logic [31:0]  fb;
    logic [31:0]  crc;
    logic [15:0]  ver;
    logic [15:0]  hlen;
    int           body;
    int           lim;
    int           pos;
    logic         calm;
    tel  = pick_len(tel_max);
    fb   = pick_len(fb_max);
    ver  = cur_version;
    hlen = 16'(HDR_N);
    case (kind)
      FR_VERSION: ver = ver ^ (16'd1 << $urandom_range(0, 15));
      FR_HDR_LEN: begin
        case ($urandom_range(0, 3))
          0: hlen = 16'h0000;
          1: hlen = 16'hffff;
          default: hlen = 16'($urandom);
        endcase
        if (hlen == 16'(HDR_N)) hlen++;
      end
      FR_TEL_RANGE: tel = out_of_range(tel_max);
      FR_FB_RANGE:  fb = out_of_range(fb_max);
      FR_BODY_SHORT: begin
        // declared lengths at times anywhere up to the limits, body short of them
        if ($urandom_range(0, 1) == 1) begin
          tel = $urandom_range(1, tel_max);
          fb  = $urandom_range(1, fb_max);
        end
      end
      default: ;
    endcase

    body = tel + fb;
    if (kind == FR_TEL_RANGE || kind == FR_FB_RANGE) begin
      body = $urandom_range(0, 8);
    end else if (kind == FR_BODY_SHORT) begin
      lim  = (body - 1 < 40) ? body - 1 : 40;
      body = $urandom_range(0, lim);
    end else if (kind == FR_TRAILING) begin
      body += $urandom_range(1, 6);
    end

    hdr_word = {32'd0, fb, tel, hlen, ver, MAGIC_3, MAGIC_2, MAGIC_1, MAGIC_0};
    for (int i = 0; i < HDR_N; i++) fr.push_back(hdr_word[8*i +: 8]);
    repeat (body) fr.push_back(8'($urandom));

    // stored crc bytes sit outside the covered span
    crc = '1;
    foreach (fr[i]) begin
      if (i < 16 || i >= HDR_N) begin
        crc = crc ^ {24'd0, fr[i]};
        repeat (8) crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : 32'd0);
      end
    end
    crc = ~crc;
    for (int i = 0; i < 4; i++) fr[16 + i] = crc[8*i +: 8];

    case (kind)
      FR_MAGIC: begin
        pos = $urandom_range(0, 3);
        fr[pos] = fr[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      FR_CRC: begin
        if (body > 0 && $urandom_range(0, 1) == 1) pos = $urandom_range(HDR_N, fr.size() - 1);
        else pos = 16 + $urandom_range(0, 3);
        fr[pos] = fr[pos] ^ (8'd1 << $urandom_range(0, 7));
      end
      FR_HDR_SHORT: begin
        lim = $urandom_range(1, HDR_N - 1);
        while (fr.size() > lim) void'(fr.pop_back());
      end
      FR_NOISE: begin
        fr.delete();
        repeat ($urandom_range(1, 45)) fr.push_back(8'($urandom));
      end
      default: ;
    endcase

    calm = (calm_frames > 0) || ($urandom_range(0, 4) == 0);
    if (calm_frames > 0) calm_frames--;
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1, calm ? 0 : gap_len());
    sent += fr.size();
  endtask

  // result side: random stalls, and a long hold once one is asked for
  initial begin
    int n;
    out_bus.ready = 1'b0;
    @(negedge clk);
    forever begin
      n = gap_len();
      if (hold_req) begin
        hold_req = 1'b0;
        n = HOLD_CYCLES;
      end
      if (n > 0) begin
        out_bus.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 30);
      do begin
        @(negedge clk);
        n--;
      end while (n > 0 && !hold_req);
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) idle = 0;
      else idle++;
    end
    $display("tb failed");
    $finish;
  end

  initial begin
    logic [23:0] ver_w;
    logic [23:0] tel_w;
    logic [23:0] fb_w;
    int          start;
    logic        paused;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = 8'd0;
    in_bus.last_byte  = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = CFG_FORMAT_VERSION;
    cfg_bus.data      = '0;
    hold_req          = 1'b0;
    sent              = 0;
    calm_frames       = 0;
    cur_version       = FORMAT_VERSION_RST;
    tel_max           = MAX_TEL_RST;
    fb_max            = MAX_FB_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte frames at both byte extremes, then a good frame
    send_byte(8'hff, 1'b1, 0);
    send_byte(8'h00, 1'b1, 0);
    send_frame(FR_OK);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        in_bus.valid <= 1'b0;
        wait (pending == 0);
        @(negedge clk);
        repeat (4) @(negedge clk);
        case (ph)
          1: begin
            ver_w = 24'h000000;
            tel_w = 24'd1;
            fb_w  = 24'd1;
          end
          2: begin
            ver_w = {8'($urandom), 16'hffff};
            tel_w = 24'hffffff;
            fb_w  = 24'hffffff;
          end
          3: begin
            ver_w = 24'($urandom);
            tel_w = 24'($urandom_range(2, 12));
            fb_w  = 24'($urandom_range(2, 12));
          end
          4: begin
            ver_w = 24'($urandom);
            tel_w = 24'($urandom_range(1, 24'hffffff));
            fb_w  = 24'($urandom_range(1, 24'hffffff));
          end
          default: begin
            ver_w = {8'($urandom), FORMAT_VERSION_RST};
            tel_w = MAX_TEL_RST;
            fb_w  = MAX_FB_RST;
          end
        endcase
        write_reg(CFG_FORMAT_VERSION, ver_w);
        write_reg(CFG_MAX_TEL, tel_w);
        write_reg(CFG_MAX_FB, fb_w);
        cfg_bus.valid <= 1'b0;
      end
      if (ph == PHASES - 1) begin
        // hold the result side off while frames keep coming, so requests back up
        hold_req    = 1'b1;
        calm_frames = 8;
      end
      start  = sent;
      paused = 1'b0;
      while (sent - start < PHASE_BYTES) begin
        if (!paused && sent - start > PHASE_BYTES / 2) begin
          paused = 1'b1;
          in_bus.valid <= 1'b0;
          wait (pending == 0);
          @(negedge clk);
        end
        if ($urandom_range(0, 1) == 0) send_frame(FR_OK);
        else send_frame(frame_kind_t'($urandom_range(FR_HDR_SHORT, FR_NOISE)));
      end
    end
    in_bus.valid <= 1'b0;

    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
